@@ hw/rtl/crs_pkg.sv @@
// Package for the Catmull-Rom spline evaluator: request/result structs, sizes, codes.
// No dependencies.
package crs_pkg;
	localparam int MAX_POINTS = 16;
	localparam int IDX_W = $clog2(MAX_POINTS);
	localparam int CNT_W = $clog2(MAX_POINTS + 1);

	typedef enum logic [1:0] {
		MODE_EVAL   = 2'd0,
		MODE_APPEND = 2'd1,
		MODE_CLEAR  = 2'd2,
		MODE_NONE   = 2'd3
	} mode_t;

	typedef struct packed {
		logic [1:0]         mode;
		logic signed [15:0] x_in;
		logic signed [15:0] y_in;
		logic [16:0]        alpha;
	} req_t;

	typedef struct packed {
		logic signed [15:0] x_out;
		logic signed [15:0] y_out;
		logic [4:0]         point_count;
		logic               table_full;
	} res_t;

	// Work passed from front to back through the queue.
	// Appends carry their point so the store is written in request order.
	typedef struct packed {
		logic               is_eval;
		logic               lin;
		logic [16:0]        t;
		logic [IDX_W-1:0]   i0;
		logic [IDX_W-1:0]   i1;
		logic [IDX_W-1:0]   i2;
		logic [IDX_W-1:0]   i3;
		logic [CNT_W-1:0]   cnt;
		logic               full;
		logic               wr;
		logic [IDX_W-1:0]   widx;
		logic signed [15:0] wx;
		logic signed [15:0] wy;
	} job_t;

	typedef enum logic [2:0] {
		BK_IDLE, BK_RD0, BK_RD1, BK_RD2, BK_RD3, BK_T2, BK_T3, BK_SUM
	} bk_state_t;

	function automatic logic signed [15:0] sat16(input logic signed [47:0] v);
		if (v > 48'sd32767) return 16'sh7fff;
		if (v < -48'sd32768) return -16'sh8000;
		return v[15:0];
	endfunction
endpackage

@@ hw/rtl/catmull_rom_spline_eval.sv @@
// Catmull-Rom spline evaluator top level: front end, job queue, back end.
// Depends on crs_pkg, crs_front, crs_queue, crs_back.
//
// Usage: drive req and raise start; a request is taken at a clock edge where
// start is high and busy is low. mode selects evaluate, append or clear.
// Each request yields exactly one result, shown on res for one cycle with
// done high; the receiver cannot stall it.
// Append, clear and evaluates with fewer than two points skip the point
// reads; other evaluates read the points through the single store read
// port, then form t^2 and t^3 on the shared multiplier, then the sum. The
// back end sequencer takes a request from the queue only when it has
// finished the last one. The front end keeps the point count and
// classifies requests; a two-entry queue lets it accept while the back end
// works. Appended points ride in the queue and are written by the back end
// in request order. busy is high while the queue is full.
// Reset clears the count, queue and sequencer; the point store is
// undefined until written.
module catmull_rom_spline_eval (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  crs_pkg::req_t req,
	output logic          busy,
	output logic          done,
	output crs_pkg::res_t res
);
	import crs_pkg::*;

	logic push, q_full, q_empty, pop;
	job_t job_f, job_b;

	assign busy = q_full;

	crs_front u_front (
		.clk, .arst_n, .start, .req, .q_full, .push, .job(job_f)
	);

	crs_queue u_queue (
		.clk, .arst_n, .push, .din(job_f), .pop, .full(q_full),
		.empty(q_empty), .dout(job_b)
	);

	crs_back u_back (
		.clk, .arst_n, .q_empty, .job(job_b), .pop, .done, .res
	);
endmodule

@@ hw/rtl/crs_front.sv @@
// Front end: accepts requests, keeps the point count, classifies evaluates.
// Depends on crs_pkg. Appended points travel to the back end inside the job.
module crs_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  crs_pkg::req_t       req,
	input  logic                q_full,
	output logic                push,
	output crs_pkg::job_t       job
);
	import crs_pkg::*;

	logic accept;
	logic [CNT_W-1:0] count_q;
	logic [16:0] al;
	logic [CNT_W+16:0] scaled;
	logic [CNT_W:0] seg;
	logic [16:0] t;
	logic [CNT_W-1:0] nm1;
	logic [CNT_W-1:0] cnt_next;
	logic is_full;

	assign accept = start && !q_full;
	assign al = (req.alpha > 17'd65536) ? 17'd65536 : req.alpha;
	assign nm1 = count_q - CNT_W'(1);
	assign scaled = al * nm1;
	assign is_full = (count_q == CNT_W'(MAX_POINTS));

	// Segment selection and end clamping
	always_comb begin
		seg = scaled[CNT_W+16:16];
		t = {1'b0, scaled[15:0]};
		if (seg >= {1'b0, nm1}) begin
			seg = {1'b0, nm1} - (CNT_W+1)'(1);
			t = 17'd65536;
		end
	end

	always_comb begin
		cnt_next = count_q;
		case (mode_t'(req.mode))
			MODE_APPEND: if (!is_full) cnt_next = count_q + CNT_W'(1);
			MODE_CLEAR:  cnt_next = '0;
			default:     cnt_next = count_q;
		endcase
	end

	// Job build
	always_comb begin
		job = '0;
		job.cnt = cnt_next;
		job.full = (req.mode == MODE_APPEND) && is_full;
		job.is_eval = (req.mode == MODE_EVAL) && (count_q >= CNT_W'(2));
		job.lin = (count_q == CNT_W'(2));
		job.wr = (req.mode == MODE_APPEND) && !is_full;
		job.widx = IDX_W'(count_q);
		job.wx = req.x_in;
		job.wy = req.y_in;
		if (job.lin) begin
			job.t = al;
			job.i1 = '0;
			job.i2 = IDX_W'(1);
			job.i0 = '0;
			job.i3 = IDX_W'(1);
		end else begin
			job.t = t;
			job.i1 = IDX_W'(seg);
			job.i2 = IDX_W'(seg + 1);
			job.i0 = (seg == '0) ? IDX_W'(0) : IDX_W'(seg - 1);
			job.i3 = ((seg + 2) <= {1'b0, nm1}) ? IDX_W'(seg + 2) : IDX_W'(seg + 1);
		end
	end

	assign push = accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) count_q <= '0;
		else if (accept) count_q <= cnt_next;
	end
endmodule

@@ hw/rtl/crs_queue.sv @@
// Two-entry queue between front and back end.
// Depends on crs_pkg.
module crs_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  crs_pkg::job_t din,
	input  logic          pop,
	output logic          full,
	output logic          empty,
	output crs_pkg::job_t dout
);
	import crs_pkg::*;

	job_t mem_q [2];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;

	assign full = (cnt_q == 2'd2);
	assign empty = (cnt_q == 2'd0);
	assign dout = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= din;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end
endmodule

@@ hw/rtl/crs_back.sv @@
// Back end: point store, four reads, powers of t, cubic or linear sum, result strobe.
// Depends on crs_pkg.
module crs_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_empty,
	input  crs_pkg::job_t       job,
	output logic                pop,
	output logic                done,
	output crs_pkg::res_t       res
);
	import crs_pkg::*;

	logic signed [15:0] px_mem [MAX_POINTS];
	logic signed [15:0] py_mem [MAX_POINTS];
	bk_state_t st_q, st_d;
	job_t job_q;
	logic [IDX_W-1:0] raddr;
	logic signed [15:0] rx_q, ry_q;
	logic signed [15:0] px_q [4];
	logic signed [15:0] py_q [4];
	logic [16:0] t2_q, t3_q;
	logic [33:0] prod;
	logic [16:0] mul_b;
	logic signed [15:0] xo, yo;
	logic res_v_q;
	res_t res_q;

	// Point store: append written in job order, one registered read
	always_ff @(posedge clk) begin
		if (st_q == BK_RD0 && job_q.wr) begin
			px_mem[job_q.widx] <= job_q.wx;
			py_mem[job_q.widx] <= job_q.wy;
		end
		rx_q <= px_mem[raddr];
		ry_q <= py_mem[raddr];
	end

	always_comb begin
		case (st_q)
			BK_RD0:  raddr = job_q.i1;
			BK_RD1:  raddr = job_q.i2;
			BK_RD2:  raddr = job_q.i3;
			default: raddr = job_q.i0;
		endcase
	end

	// Shared t multiplier with rounding
	assign mul_b = (st_q == BK_T2) ? job_q.t : t2_q;
	assign prod = job_q.t * mul_b;

	always_comb begin
		st_d = st_q;
		pop = 1'b0;
		case (st_q)
			BK_IDLE: if (!q_empty) begin
				pop = 1'b1;
				st_d = BK_RD0;
			end
			BK_RD0:  st_d = job_q.is_eval ? BK_RD1 : BK_SUM;
			BK_RD1:  st_d = BK_RD2;
			BK_RD2:  st_d = BK_RD3;
			BK_RD3:  st_d = BK_T2;
			BK_T2:   st_d = BK_T3;
			BK_T3:   st_d = BK_SUM;
			BK_SUM:  st_d = BK_IDLE;
			default: st_d = BK_IDLE;
		endcase
	end

	function automatic logic signed [15:0] eval1(
		input logic signed [15:0] p0, input logic signed [15:0] p1,
		input logic signed [15:0] p2, input logic signed [15:0] p3,
		input logic lin, input logic [16:0] t, input logic [16:0] t2,
		input logic [16:0] t3);
		logic signed [19:0] a, b, c, d, df;
		logic signed [47:0] s;
		begin
			a = -20'(p0) + 20'sd3 * 20'(p1) - 20'sd3 * 20'(p2) + 20'(p3);
			b = 20'sd2 * 20'(p0) - 20'sd5 * 20'(p1) + 20'sd4 * 20'(p2) - 20'(p3);
			c = 20'(p2) - 20'(p0);
			d = 20'sd2 * 20'(p1);
			df = 20'(p2) - 20'(p1);
			if (lin) begin
				s = (48'(p1) <<< 16) + 48'(df) * $signed({31'd0, t}) + 48'sd32768;
				return sat16(s >>> 16);
			end
			s = 48'(a) * $signed({31'd0, t3}) + 48'(b) * $signed({31'd0, t2})
				+ 48'(c) * $signed({31'd0, t}) + (48'(d) <<< 16) + 48'sd65536;
			return sat16(s >>> 17);
		end
	endfunction

	assign xo = eval1(px_q[0], px_q[1], px_q[2], px_q[3], job_q.lin, job_q.t, t2_q, t3_q);
	assign yo = eval1(py_q[0], py_q[1], py_q[2], py_q[3], job_q.lin, job_q.t, t2_q, t3_q);

	always_ff @(posedge clk) begin
		if (pop) job_q <= job;
		case (st_q)
			BK_RD1: begin px_q[1] <= rx_q; py_q[1] <= ry_q; end
			BK_RD2: begin px_q[2] <= rx_q; py_q[2] <= ry_q; end
			BK_RD3: begin px_q[3] <= rx_q; py_q[3] <= ry_q; end
			BK_T2:  t2_q <= 17'((prod + 34'd32768) >> 16);
			BK_T3:  t3_q <= 17'((prod + 34'd32768) >> 16);
			default: ;
		endcase
		if (pop) begin px_q[0] <= 16'sd0; py_q[0] <= 16'sd0; end
		// i0 is read last, its data lands during T2
		if (st_q == BK_T2) begin px_q[0] <= rx_q; py_q[0] <= ry_q; end
		if (st_q == BK_SUM) begin
			res_q.x_out <= job_q.is_eval ? xo : 16'sd0;
			res_q.y_out <= job_q.is_eval ? yo : 16'sd0;
			res_q.point_count <= 5'(job_q.cnt);
			res_q.table_full <= job_q.full;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= BK_IDLE;
			res_v_q <= 1'b0;
		end else begin
			st_q <= st_d;
			res_v_q <= (st_q == BK_SUM);
		end
	end

	assign done = res_v_q;
	assign res = res_q;
endmodule

@@ hw/rtl/crs_checker.sv @@
// Port-level checker for the spline evaluator, bound to the top level.
// Depends on crs_pkg.
module crs_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          done,
	input crs_pkg::res_t res
);
	import crs_pkg::*;

	// Results never come on back-to-back cycles
	a_gap: assert property (@(posedge clk) disable iff (!arst_n) done |=> !done)
		else $error("done on consecutive cycles");

	// Reported count never exceeds the table size
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> res.point_count <= 5'(MAX_POINTS))
		else $error("point count over table size");

	// Only a rejected append flags full, so the count must be at maximum
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		(done && res.table_full) |-> (res.point_count == 5'(MAX_POINTS)))
		else $error("table_full with count below maximum");

	// Flag requests carry no coordinates
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && res.table_full) |-> (res.x_out == 16'sd0 && res.y_out == 16'sd0))
		else $error("rejected append returned coordinates");
endmodule

bind catmull_rom_spline_eval crs_checker u_crs_checker (
	.clk, .arst_n, .done, .res
);
